>>> rtl/core/tcma_pkg.sv
`timescale 1ns / 1ps
// tcma_pkg: constants, types and the reciprocal table of the moving-average block
// no dependencies

package tcma_pkg;

  localparam int WINDOW     = 5;
  localparam int SAMPLE_W   = 16;
  localparam int SEQ_W      = 32;
  localparam int FILL_OUT_W = 3;
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = SAMPLE_W + FILL_W;
  localparam int RECIP_K    = SUM_W + FILL_W;
  localparam int RECIP_W    = RECIP_K + 1;
  localparam int CH_W       = 2;

  localparam logic [CH_W-1:0] CH_TEMP = 2'd0;
  localparam logic [CH_W-1:0] CH_CURR = 2'd1;
  localparam logic [CH_W-1:0] CH_VIB  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  // ceil(2^RECIP_K / d): exact quotient for any sum magnitude the window can reach
  function automatic logic [RECIP_W-1:0] recip_f(input logic [4:0] d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      5'd1:    r = RECIP_W'((2 ** RECIP_K + 0) / 1);
      5'd2:    r = RECIP_W'((2 ** RECIP_K + 1) / 2);
      5'd3:    r = RECIP_W'((2 ** RECIP_K + 2) / 3);
      5'd4:    r = RECIP_W'((2 ** RECIP_K + 3) / 4);
      5'd5:    r = RECIP_W'((2 ** RECIP_K + 4) / 5);
      5'd6:    r = RECIP_W'((2 ** RECIP_K + 5) / 6);
      5'd7:    r = RECIP_W'((2 ** RECIP_K + 6) / 7);
      5'd8:    r = RECIP_W'((2 ** RECIP_K + 7) / 8);
      5'd9:    r = RECIP_W'((2 ** RECIP_K + 8) / 9);
      5'd10:   r = RECIP_W'((2 ** RECIP_K + 9) / 10);
      5'd11:   r = RECIP_W'((2 ** RECIP_K + 10) / 11);
      5'd12:   r = RECIP_W'((2 ** RECIP_K + 11) / 12);
      5'd13:   r = RECIP_W'((2 ** RECIP_K + 12) / 13);
      5'd14:   r = RECIP_W'((2 ** RECIP_K + 13) / 14);
      5'd15:   r = RECIP_W'((2 ** RECIP_K + 14) / 15);
      5'd16:   r = RECIP_W'((2 ** RECIP_K + 15) / 16);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/tcma_if.sv
`timescale 1ns / 1ps
// tcma_in_if / tcma_out_if: valid-ready channels for sample and result words
// depends on tcma_pkg

interface tcma_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tcma_pkg::SAMPLE_W-1:0] temperature_sample;
  logic signed [tcma_pkg::SAMPLE_W-1:0] current_sample;
  logic signed [tcma_pkg::SAMPLE_W-1:0] vibration_sample;
  logic        [tcma_pkg::SEQ_W-1:0]    sequence_number;

  modport source (
    output valid, temperature_sample, current_sample, vibration_sample, sequence_number,
    input  ready
  );
  modport sink (
    input  valid, temperature_sample, current_sample, vibration_sample, sequence_number,
    output ready
  );
endinterface

interface tcma_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tcma_pkg::SAMPLE_W-1:0]   temperature_average;
  logic signed [tcma_pkg::SAMPLE_W-1:0]   current_average;
  logic signed [tcma_pkg::SAMPLE_W-1:0]   vibration_average;
  logic        [tcma_pkg::SEQ_W-1:0]      sequence_out;
  logic        [tcma_pkg::FILL_OUT_W-1:0] window_fill;

  modport source (
    output valid, temperature_average, current_average, vibration_average, sequence_out,
           window_fill,
    input  ready
  );
  modport sink (
    input  valid, temperature_average, current_average, vibration_average, sequence_out,
           window_fill,
    output ready
  );
endinterface

>>> rtl/core/tcma_div.sv
`timescale 1ns / 1ps
// tcma_div: shared divide-by-fill unit, reciprocal multiply then shift and sign restore
// depends on tcma_pkg

module tcma_div (
  input  logic                                 clk_i,
  input  logic                                 issue_i,
  input  logic signed [tcma_pkg::SUM_W-1:0]    sum_i,
  input  logic        [tcma_pkg::FILL_W-1:0]   fill_i,
  output logic signed [tcma_pkg::SAMPLE_W-1:0] quot_o
);
  import tcma_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod_q;
  logic              neg_q;
  logic [SUM_W-1:0]  quot_mag;
  logic [SUM_W-1:0]  quot_signed;

  assign neg    = sum_i[SUM_W-1];
  assign mag    = neg ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign prod_d = PROD_W'(mag) * PROD_W'(recip_f(5'(fill_i)));

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= prod_d;
      neg_q  <= neg;
    end
  end

  // truncation toward zero: divide the magnitude, then put the sign back
  assign quot_mag    = prod_q[RECIP_K +: SUM_W];
  assign quot_signed = neg_q ? (~quot_mag + SUM_W'(1)) : quot_mag;
  assign quot_o      = quot_signed[SAMPLE_W-1:0];

endmodule

>>> rtl/core/three_channel_moving_average.sv
`timescale 1ns / 1ps
// three_channel_moving_average: boxcar mean over the last WINDOW words, three channels
// depends on tcma_pkg, tcma_if, tcma_div
//
//   channel    dir   payload
//   sample_i   in    temperature/current/vibration sample, sequence number
//   result_o   out   three averages, sequence number, window fill
//
// one word goes through accept with ring and sum update, three issues of the
// shared reciprocal multiplier (one per channel), and a finish state that loads the
// output register. ready is high only between words.
// reset clears rings, sums, write position and fill count at once.
// a stalled result holds the finish cycle; a waiting result does not block the next word.

module three_channel_moving_average (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcma_in_if.sink    sample_i,
  tcma_out_if.source result_o
);
  import tcma_pkg::*;

  state_e state_q, state_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic [POS_W-1:0] pos_q;
  logic [FILL_W-1:0] fill_q;
  logic signed [SUM_W-1:0] t_sum_q, c_sum_q, v_sum_q;
  logic signed [SAMPLE_W-1:0] t_ring_q [WINDOW];
  logic signed [SAMPLE_W-1:0] c_ring_q [WINDOW];
  logic signed [SAMPLE_W-1:0] v_ring_q [WINDOW];
  logic signed [SAMPLE_W-1:0] t_avg_q, c_avg_q;
  logic [SEQ_W-1:0] seq_q;

  logic out_valid_q;
  logic signed [SAMPLE_W-1:0] out_t_q, out_c_q, out_v_q;
  logic [SEQ_W-1:0] out_seq_q;
  logic [FILL_OUT_W-1:0] out_fill_q;

  logic accept, issue, load;
  logic [POS_W-1:0] pos_eff, pos_next;
  logic signed [SUM_W-1:0] div_sum;
  logic signed [SAMPLE_W-1:0] div_quot;

  assign accept         = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == S_IDLE);
  assign issue          = (state_q == S_DIV);
  assign load           = (state_q == S_FIN) && (!out_valid_q || result_o.ready);

  assign pos_eff  = ({1'b0, pos_q} < (POS_W + 1)'(WINDOW)) ? pos_q : '0;
  assign pos_next = ({1'b0, pos_eff} == (POS_W + 1)'(WINDOW - 1)) ? '0 : pos_eff + POS_W'(1);

  always_comb begin
    unique case (ch_q)
      CH_TEMP: div_sum = t_sum_q;
      CH_CURR: div_sum = c_sum_q;
      default: div_sum = v_sum_q;
    endcase
  end

  tcma_div u_div (
    .clk_i   (clk_i),
    .issue_i (issue),
    .sum_i   (div_sum),
    .fill_i  (fill_q),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DIV;
          ch_d    = CH_TEMP;
        end
      end
      S_DIV: begin
        if (ch_q == CH_VIB) begin
          state_d = S_FIN;
          ch_d    = CH_TEMP;
        end else begin
          ch_d = ch_q + CH_W'(1);
        end
      end
      S_FIN: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        ch_d    = CH_TEMP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= CH_TEMP;
      pos_q   <= '0;
      fill_q  <= '0;
      t_sum_q <= '0;
      c_sum_q <= '0;
      v_sum_q <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        t_ring_q[i] <= '0;
        c_ring_q[i] <= '0;
        v_ring_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (accept) begin
        // oldest entry leaves the sum, new sample enters
        t_sum_q <= t_sum_q - SUM_W'(t_ring_q[pos_eff]) + SUM_W'(sample_i.temperature_sample);
        c_sum_q <= c_sum_q - SUM_W'(c_ring_q[pos_eff]) + SUM_W'(sample_i.current_sample);
        v_sum_q <= v_sum_q - SUM_W'(v_ring_q[pos_eff]) + SUM_W'(sample_i.vibration_sample);
        t_ring_q[pos_eff] <= sample_i.temperature_sample;
        c_ring_q[pos_eff] <= sample_i.current_sample;
        v_ring_q[pos_eff] <= sample_i.vibration_sample;
        pos_q <= pos_next;
        if (fill_q < FILL_W'(WINDOW)) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
    end
  end

  // payload side
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q <= sample_i.sequence_number;
    end
    if (issue && ch_q == CH_CURR) begin
      t_avg_q <= div_quot;
    end
    if (issue && ch_q == CH_VIB) begin
      c_avg_q <= div_quot;
    end
    if (load) begin
      out_t_q    <= t_avg_q;
      out_c_q    <= c_avg_q;
      out_v_q    <= div_quot;
      out_seq_q  <= seq_q;
      out_fill_q <= FILL_OUT_W'(fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign result_o.valid               = out_valid_q;
  assign result_o.temperature_average = out_t_q;
  assign result_o.current_average     = out_c_q;
  assign result_o.vibration_average   = out_v_q;
  assign result_o.sequence_out        = out_seq_q;
  assign result_o.window_fill         = out_fill_q;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fill_q} <= (FILL_W + 1)'(WINDOW))
    else $error("fill count beyond window");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < (POS_W + 1)'(WINDOW))
    else $error("write position out of range");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DIV && ch_q == CH_TEMP))
    else $error("accepted word did not start the divide sequence");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result word appeared outside the finish cycle");

  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> fill_q != '0)
    else $error("result word with empty window");

endmodule

>>> sim/tcma_checker.sv
`timescale 1ns / 1ps
// tcma_checker: watches the sample and result channels of the moving-average block,
// predicts each average word and compares it with what the block delivers
// depends on tcma_pkg, tcma_if

module tcma_checker
  import tcma_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tcma_in_if   sample_mon,
  tcma_out_if  result_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] temperature;
    logic signed [SAMPLE_W-1:0] current;
    logic signed [SAMPLE_W-1:0] vibration;
    logic [SEQ_W-1:0]           seq;
    logic [FILL_OUT_W-1:0]      fill;
  } average_word_t;

  logic signed [SAMPLE_W-1:0] history [3][WINDOW];
  int                         window_sum [3];
  int                         slot;
  int                         fill_level;
  int                         mismatches;
  average_word_t              average_q [$];

  task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] t,
                               input logic signed [SAMPLE_W-1:0] c,
                               input logic signed [SAMPLE_W-1:0] v,
                               input logic [SEQ_W-1:0] seq);
    logic signed [SAMPLE_W-1:0] fresh [3];
    int                         mean [3];
    int                         ch;
    average_word_t              w;
    fresh[0] = t;
    fresh[1] = c;
    fresh[2] = v;
    if (slot >= WINDOW) slot = 0;
    for (ch = 0; ch < 3; ch++) begin
      window_sum[ch] = window_sum[ch] - int'(history[ch][slot]) + int'(fresh[ch]);
      history[ch][slot] = fresh[ch];
    end
    slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    if (fill_level < WINDOW) fill_level++;
    // integer division truncates toward zero
    for (ch = 0; ch < 3; ch++) mean[ch] = window_sum[ch] / fill_level;
    w.temperature = SAMPLE_W'(mean[0]);
    w.current     = SAMPLE_W'(mean[1]);
    w.vibration   = SAMPLE_W'(mean[2]);
    w.seq         = seq;
    w.fill        = FILL_OUT_W'(fill_level);
    average_q.push_back(w);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    average_word_t w;
    if (!rst_ni) begin
      for (int ch = 0; ch < 3; ch++) begin
        window_sum[ch] = 0;
        for (int i = 0; i < WINDOW; i++) history[ch][i] = '0;
      end
      slot        = 0;
      fill_level  = 0;
      mismatches  = 0;
      average_q.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (average_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, seq %h", $time, result_mon.sequence_out);
        end else begin
          w = average_q.pop_front();
          check_field("temperature_average", 32'(w.temperature),
                      32'(result_mon.temperature_average));
          check_field("current_average", 32'(w.current), 32'(result_mon.current_average));
          check_field("vibration_average", 32'(w.vibration),
                      32'(result_mon.vibration_average));
          check_field("sequence_out", w.seq, result_mon.sequence_out);
          check_field("window_fill", 32'(w.fill), 32'(result_mon.window_fill));
        end
      end
      if (sample_mon.valid && sample_mon.ready)
        absorb_sample(sample_mon.temperature_sample, sample_mon.current_sample,
                      sample_mon.vibration_sample, sample_mon.sequence_number);
    end
    fail_count_o <= mismatches;
    pending_o    <= average_q.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// testbench: drives sample words into three_channel_moving_average with random gaps
// and output stalls; tcma_checker predicts and compares the average words
// depends on tcma_pkg, tcma_if, tcma_checker and the block itself

module testbench;
  import tcma_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          send_idle;
  bit          recv_idle;
  logic [SEQ_W-1:0] seq_ctr;

  tcma_in_if  sample_ch ();
  tcma_out_if result_ch ();

  three_channel_moving_average uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  tcma_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_ch),
    .result_mon   (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    result_ch.ready <= !(recv_idle && $urandom_range(99) < 22);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] t,
                             input logic signed [SAMPLE_W-1:0] c,
                             input logic signed [SAMPLE_W-1:0] v,
                             input logic [SEQ_W-1:0] seq);
    while (send_idle && $urandom_range(99) < 22) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid              <= 1'b1;
    sample_ch.temperature_sample <= t;
    sample_ch.current_sample     <= c;
    sample_ch.vibration_sample   <= v;
    sample_ch.sequence_number    <= seq;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return SAMPLE_W'($urandom_range(16) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_random();
    if ($urandom_range(7) == 0) seq_ctr = $urandom;
    else seq_ctr = seq_ctr + 1;
    send_sample(pick_sample(), pick_sample(), pick_sample(), seq_ctr);
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni                       = 1'b0;
    sample_ch.valid              = 1'b0;
    sample_ch.temperature_sample = '0;
    sample_ch.current_sample     = '0;
    sample_ch.vibration_sample   = '0;
    sample_ch.sequence_number    = '0;
    send_idle                    = 1'b0;
    recv_idle                    = 1'b1;
    seq_ctr                      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill from reset at the extremes, then run with a full window
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0000, 32'h0000_0000);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0000, 32'hFFFF_FFFF);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0000, 32'h5555_5555);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0000, 32'hAAAA_AAAA);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0000, 32'h0000_0001);
    for (int i = 0; i < 5; i++) send_sample(16'sh8000, 16'sh7FFF, 16'shFFFF, SEQ_W'(2 + i));
    // small values, negative sums that do not divide evenly
    for (int i = 0; i < 6; i++)
      send_sample(SAMPLE_W'(-1 - i), SAMPLE_W'(i), SAMPLE_W'(3 * i - 7), SEQ_W'(7 + i));
    for (int i = 0; i < 4; i++)
      send_sample((i % 2) ? 16'sh7FFF : 16'sh8001, (i % 2) ? 16'sh8001 : 16'sh7FFF,
                  SAMPLE_W'(i - 2), SEQ_W'(13 + i));
    seq_ctr = 100;

    send_idle = 1'b1;
    repeat (300) send_random();
    wait_drained();

    // long stretch with no idling on either side
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (150) send_random();

    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (400) send_random();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
